@@ rtl/zhne_pkg.sv @@
// Package for the ZIP local header name extractor.
// Holds the channel item types, phase and result kind codes, and header constants.
// No dependencies.
package zhne_pkg;

	localparam logic [31:0] SIG_WORD       = 32'h504B0304;
	localparam logic [4:0]  POS_LEN_LOW    = 5'd23;
	localparam logic [4:0]  POS_LEN_HIGH   = 5'd24;
	localparam logic [4:0]  POS_NAME_START = 5'd27;
	localparam int          SHOWN_WIDTH    = 32;

	typedef enum logic [1:0] {
		PH_SCAN   = 2'd0,
		PH_HEADER = 2'd1,
		PH_NAME   = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NAME    = 2'd0,
		KIND_EMPTY   = 2'd1,
		KIND_SUMMARY = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_marker;
	} src_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  name_byte;
		logic        last_of_name;
		logic [31:0] record_count;
		logic        found_any;
		logic        truncated;
	} res_item_t;

	typedef struct packed {
		logic scanning;
		logic count_zero;
	} core_status_t;

endpackage

@@ rtl/zhne_core.sv @@
// Scanner state and per-item step logic of the ZIP local header name extractor.
// Holds the byte window, phase, header position, name length and record counter.
// Depends on zhne_pkg.
module zhne_core
	import zhne_pkg::*;
#(
	parameter int COUNT_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  src_item_t    item,
	input  logic         fire,
	output logic         has_result,
	output res_item_t    result,
	output core_status_t status
);

	localparam int SHOW_W = (COUNT_WIDTH < SHOWN_WIDTH) ? COUNT_WIDTH : SHOWN_WIDTH;

	logic [31:0]            window_q, window_n;
	phase_t                 phase_q, phase_n;
	logic [4:0]             pos_q, pos_n;
	logic [7:0]             len_low_q, len_low_n;
	logic [15:0]            remain_q, remain_n;
	logic [COUNT_WIDTH-1:0] count_q, count_n, count_bumped;

	assign count_bumped = (&count_q) ? count_q : count_q + COUNT_WIDTH'(1);

	always_comb begin
		window_n   = {window_q[23:0], item.data_byte};
		phase_n    = phase_q;
		pos_n      = pos_q;
		len_low_n  = len_low_q;
		remain_n   = remain_q;
		count_n    = count_q;
		has_result = 1'b0;
		result     = '{kind: KIND_NAME, name_byte: 8'd0, last_of_name: 1'b0,
		               record_count: 32'd0, found_any: 1'b0, truncated: 1'b0};

		if (item.end_marker) begin
			has_result          = 1'b1;
			result.kind         = KIND_SUMMARY;
			result.record_count = 32'(count_q[SHOW_W-1:0]);
			result.found_any    = (count_q != '0);
			result.truncated    = (phase_q == PH_HEADER) || (phase_q == PH_NAME);
			window_n            = 32'd0;
			phase_n             = PH_SCAN;
			pos_n               = 5'd0;
			len_low_n           = 8'd0;
			remain_n            = 16'd0;
			count_n             = '0;
		end else begin
			case (phase_q)
				PH_HEADER: begin
					pos_n = pos_q + 5'd1;
					if (pos_n == POS_LEN_LOW) begin
						len_low_n = item.data_byte;
					end else if (pos_n == POS_LEN_HIGH) begin
						remain_n = {item.data_byte, len_low_q};
					end else if (pos_n == POS_NAME_START - 5'd1) begin
						if (remain_q == 16'd0) begin
							// Zero-length name: report an empty record in place of name bytes.
							count_n             = count_bumped;
							phase_n             = PH_SCAN;
							pos_n               = 5'd0;
							has_result          = 1'b1;
							result.kind         = KIND_EMPTY;
							result.last_of_name = 1'b1;
							result.record_count = 32'(count_bumped[SHOW_W-1:0]);
						end else begin
							phase_n = PH_NAME;
						end
					end
				end
				PH_NAME: begin
					remain_n            = remain_q - 16'd1;
					has_result          = 1'b1;
					result.kind         = KIND_NAME;
					result.name_byte    = item.data_byte;
					result.last_of_name = (remain_n == 16'd0);
					result.record_count = 32'(count_q[SHOW_W-1:0]);
					if (remain_n == 16'd0) begin
						count_n             = count_bumped;
						phase_n             = PH_SCAN;
						pos_n               = 5'd0;
						result.record_count = 32'(count_bumped[SHOW_W-1:0]);
					end
				end
				default: begin
					// The unused phase code behaves as scanning.
					phase_n = PH_SCAN;
					if (window_n == SIG_WORD) begin
						phase_n = PH_HEADER;
						pos_n   = 5'd0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= 32'd0;
			phase_q   <= PH_SCAN;
			pos_q     <= 5'd0;
			len_low_q <= 8'd0;
			remain_q  <= 16'd0;
			count_q   <= '0;
		end else if (fire) begin
			window_q  <= window_n;
			phase_q   <= phase_n;
			pos_q     <= pos_n;
			len_low_q <= len_low_n;
			remain_q  <= remain_n;
			count_q   <= count_n;
		end
	end

	assign status.scanning   = (phase_q == PH_SCAN);
	assign status.count_zero = (count_q == '0);

endmodule

@@ rtl/zhne_out_buf.sv @@
// Result register of the ZIP local header name extractor.
// Holds one result item until the consumer takes it.
// Depends on zhne_pkg.
module zhne_out_buf
	import zhne_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  res_item_t load_item,
	output logic      free,
	output logic      res_valid,
	input  logic      res_ready,
	output res_item_t res_data
);

	logic      valid_q;
	res_item_t data_q;

	assign free      = !valid_q || res_ready;
	assign res_valid = valid_q;
	assign res_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_item;
		end
	end

endmodule

@@ rtl/zip_header_name_extractor.sv @@
// Scans a byte stream for ZIP local file headers and emits each file name byte by byte, an
// empty-name record for a zero-length name, and a summary on an end-of-stream item. One item
// is taken per clock cycle unless the input stalls; an item is held in the input register,
// and its result is loaded into the result register when the held item moves on. The input
// stalls only while the result register is full, not taken, and the held item has a result.
// Depends on zhne_pkg, zhne_core and zhne_out_buf.
module zip_header_name_extractor
	import zhne_pkg::*;
#(
	parameter int COUNT_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_ready,
	input  src_item_t src_data,
	output logic      res_valid,
	input  logic      res_ready,
	output res_item_t res_data
);

	logic         valid_s1;
	src_item_t    item_s1;
	logic         has_result;
	res_item_t    result;
	core_status_t status;
	logic         out_free;
	logic         advance;

	// The held item moves on when its result (if any) has a place to go.
	assign advance   = valid_s1 && (!has_result || out_free);
	assign src_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_ready) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_ready && src_valid) begin
			item_s1 <= src_data;
		end
	end

	zhne_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_s1),
		.fire      (advance),
		.has_result(has_result),
		.result    (result),
		.status    (status)
	);

	zhne_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && has_result),
		.load_item(result),
		.free     (out_free),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data (res_data)
	);

`ifndef ASSERT_OFF
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.end_marker |=> status.scanning && status.count_zero)
		else $error("state not cleared after end of stream");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		!src_ready |-> valid_s1 && has_result && res_valid && !res_ready)
		else $error("input stalled without a blocked result");

	a_summary_kind: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.end_marker |=> res_valid && res_data.kind == KIND_SUMMARY)
		else $error("end of stream did not produce a summary");
`endif

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for zip_header_name_extractor: a queue-fed byte driver, a clocked
// monitor with a built-in scanner model, and a receiver that stalls at random.
// Depends on zhne_pkg and the zip_header_name_extractor RTL.
module tb;
	import zhne_pkg::*;

	localparam int CNT_W = 8;
	localparam logic [63:0] CNT_MAX = (CNT_W >= 64) ? {64{1'b1}} : (64'd1 << CNT_W) - 64'd1;
	localparam int HDR_LEN = POS_NAME_START - 1;
	localparam int LONG_HOLD = 300;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic src_ready;
	src_item_t src_data = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_item_t res_data;

	src_item_t pending_items[$];
	res_item_t expected_results[$];

	int unsigned stim_count = 0;
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	logic src_took = 1'b0;
	logic hold_go = 1'b0;
	logic hold_begun = 1'b0;
	int unsigned hold_left = 0;

	// Scanner model state.
	logic [31:0] win;
	phase_t ph;
	logic [4:0] hdr_pos;
	logic [7:0] len_lo;
	logic [15:0] name_left;
	logic [63:0] rec_cnt;

	zip_header_name_extractor #(.COUNT_WIDTH(CNT_W)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.src_data(src_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data(res_data)
	);

	always #4 clk = ~clk;

	function automatic logic [7:0] sig_byte(input int j);
		return SIG_WORD[31 - 8 * j -: 8];
	endfunction

	function automatic int pick_name_len();
		int r;
		r = $urandom_range(19);
		if (r == 0) begin
			return 0;
		end
		if (r == 1) begin
			return $urandom_range(13, 80);
		end
		return $urandom_range(1, 12);
	endfunction

	task automatic clear_scanner();
		win = '0;
		ph = PH_SCAN;
		hdr_pos = '0;
		len_lo = '0;
		name_left = '0;
		rec_cnt = '0;
	endtask

	task automatic bump_records();
		if (rec_cnt < CNT_MAX) begin
			rec_cnt = rec_cnt + 64'd1;
		end
	endtask

	// Advances the model by one item and reports the result it causes, if any.
	task automatic scan_item(input src_item_t it, output bit emits, output res_item_t r);
		r = '0;
		emits = 1'b0;
		if (it.end_marker) begin
			r.kind = KIND_SUMMARY;
			r.record_count = rec_cnt[31:0];
			r.found_any = (rec_cnt != 64'd0);
			r.truncated = (ph == PH_HEADER) || (ph == PH_NAME);
			emits = 1'b1;
			clear_scanner();
		end else begin
			win = {win[23:0], it.data_byte};
			case (ph)
				PH_HEADER: begin
					hdr_pos = hdr_pos + 5'd1;
					if (hdr_pos == POS_LEN_LOW) begin
						len_lo = it.data_byte;
					end else if (hdr_pos == POS_LEN_HIGH) begin
						name_left = {it.data_byte, len_lo};
					end else if (hdr_pos == POS_NAME_START - 5'd1) begin
						if (name_left == 16'd0) begin
							bump_records();
							ph = PH_SCAN;
							hdr_pos = '0;
							r.kind = KIND_EMPTY;
							r.last_of_name = 1'b1;
							r.record_count = rec_cnt[31:0];
							emits = 1'b1;
						end else begin
							ph = PH_NAME;
						end
					end
				end
				PH_NAME: begin
					name_left = name_left - 16'd1;
					if (name_left == 16'd0) begin
						bump_records();
						ph = PH_SCAN;
						hdr_pos = '0;
					end
					r.kind = KIND_NAME;
					r.name_byte = it.data_byte;
					r.last_of_name = (name_left == 16'd0);
					r.record_count = rec_cnt[31:0];
					emits = 1'b1;
				end
				default: begin
					ph = PH_SCAN;
					if (win == SIG_WORD) begin
						ph = PH_HEADER;
						hdr_pos = '0;
					end
				end
			endcase
		end
	endtask

	task automatic flag_field(input string field, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		end
	endtask

	task automatic add_byte(input logic [7:0] b);
		pending_items.push_back(src_item_t'{data_byte: b, end_marker: 1'b0});
		stim_count++;
	endtask

	task automatic add_end(input logic [7:0] b);
		pending_items.push_back(src_item_t'{data_byte: b, end_marker: 1'b1});
		stim_count++;
	endtask

	task automatic add_sig();
		for (int j = 0; j < 4; j++) begin
			add_byte(sig_byte(j));
		end
	endtask

	// Header and name bytes that follow a signature. A fill of -1 gives random bytes.
	// Any nonzero plant mode hides a whole signature in the header; mode 1 also ends the name
	// with a whole signature, mode 2 with its first three bytes. A cut of -1 sends everything.
	task automatic add_record(input int name_len, input int fill, input int plant, input int cut);
		logic [7:0] b;
		int k;
		for (int p = 1; p <= HDR_LEN + name_len; p++) begin
			if (cut >= 0 && p > cut) begin
				break;
			end
			b = (fill >= 0) ? fill[7:0] : 8'($urandom);
			if (p == POS_LEN_LOW) begin
				b = name_len[7:0];
			end else if (p == POS_LEN_HIGH) begin
				b = name_len[15:8];
			end else if (p <= HDR_LEN) begin
				if (plant != 0 && p >= 5 && p <= 8) begin
					b = sig_byte(p - 5);
				end
			end else begin
				k = p - POS_NAME_START;
				if (plant == 1 && name_len >= 4 && k >= name_len - 4) begin
					b = sig_byte(k - (name_len - 4));
				end else if (plant == 2 && name_len >= 3 && k >= name_len - 3) begin
					b = sig_byte(k - (name_len - 3));
				end
			end
			add_byte(b);
		end
	endtask

	task automatic add_random_traffic(input int unsigned target);
		int unsigned start;
		int pick;
		int len;
		int plant;
		start = stim_count;
		while (stim_count - start < target) begin
			pick = $urandom_range(99);
			len = pick_name_len();
			if (pick < 60) begin
				plant = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
				add_sig();
				add_record(len, -1, plant, -1);
				// Let the next signature begin inside the name just finished.
				if (plant == 2 && $urandom_range(1) == 1) begin
					add_byte(sig_byte(3));
					add_record(pick_name_len(), -1, 0, -1);
				end
			end else if (pick < 72) begin
				// Noise between headers, sometimes a signature that breaks off.
				if ($urandom_range(2) == 0) begin
					for (int j = 0; j < 3; j++) begin
						add_byte(sig_byte(j));
					end
				end
				for (int j = $urandom_range(1, 6); j > 0; j--) begin
					add_byte(8'($urandom));
				end
			end else if (pick < 84) begin
				add_sig();
				add_record(len, -1, 0, $urandom_range(0, HDR_LEN + len - 1));
				add_end(8'($urandom));
			end else begin
				add_end(8'($urandom));
			end
		end
	endtask

	// Driver: a new item goes out only once the previous one has been taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
		end else if (!src_valid || src_took) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				src_data <= pending_items.pop_front();
				src_valid <= 1'b1;
			end else begin
				src_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off on request.
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else if (hold_go && !hold_begun) begin
			hold_begun <= 1'b1;
			hold_left <= LONG_HOLD;
			res_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin : monitor
		bit emits;
		res_item_t predicted;
		res_item_t want;
		if (!arst_n) begin
			src_took <= 1'b0;
		end else begin
			src_took <= src_valid && src_ready;
			if (src_valid && src_ready) begin
				scan_item(src_data, emits, predicted);
				if (emits) begin
					expected_results.push_back(predicted);
				end
			end
			if (res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result, expected none, actual %0h", $time,
						res_data);
				end else begin
					want = expected_results.pop_front();
					flag_field("kind", 32'(want.kind), 32'(res_data.kind));
					flag_field("name_byte", 32'(want.name_byte), 32'(res_data.name_byte));
					flag_field("last_of_name", 32'(want.last_of_name),
						32'(res_data.last_of_name));
					flag_field("record_count", want.record_count, res_data.record_count);
					flag_field("found_any", 32'(want.found_any), 32'(res_data.found_any));
					flag_field("truncated", 32'(want.truncated), 32'(res_data.truncated));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** zip_header_name_extractor: FAILED **");
			$finish;
		end
	end

	initial begin
		clear_scanner();
		tx_idle_pct = 18;
		rx_idle_pct = 49;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part.
		add_end(8'hFF);
		add_sig();
		add_record(1, 8'hFF, 0, -1);
		add_sig();
		add_record(1, 8'h00, 0, -1);
		add_sig();
		add_record(0, -1, 0, -1);
		add_end(8'h00);
		add_sig();
		add_record(6, -1, 1, -1);
		add_sig();
		add_record(5, -1, 2, -1);
		add_byte(sig_byte(3));
		add_record(2, -1, 0, -1);
		add_sig();
		add_record(256, -1, 0, -1);
		add_sig();
		add_end(8'h5A);
		add_sig();
		add_record(4, -1, 0, 10);
		add_end(8'hA5);
		add_sig();
		add_record(5, -1, 0, HDR_LEN + 2);
		add_end(8'h00);
		add_end(8'hFF);
		add_sig();
		add_record(2, -1, 0, -1);
		add_end(8'h00);

		add_random_traffic(80);
		while (pending_items.size() != 0) @(posedge clk);
		tx_idle_pct = 49;
		rx_idle_pct = 18;
		add_random_traffic(80);
		while (pending_items.size() != 0) @(posedge clk);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		add_random_traffic(90);
		hold_go = 1'b1;

		while (pending_items.size() != 0 || src_valid || expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("** zip_header_name_extractor: PASSED **");
		end else begin
			$display("** zip_header_name_extractor: FAILED **");
		end
		$finish;
	end

endmodule
